/* hdl/sact_pkg.sv */
// sact_pkg: shared constants, types and helpers for the set-associative tag lookup
// used by every module of the block; no dependencies

package sact_pkg;

  // fixed field widths
  localparam int ADDR_W      = 32;
  localparam int WLOG_W      = 2;
  localparam int SEED_W      = 16;
  localparam int WAY_W       = 3;
  localparam int CNT_W       = 32;
  localparam int OUT_TDATA_W = 72;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // parameter defaults
  localparam int CACHE_BYTES_LOG2_DEF = 15;
  localparam int LINE_BYTES_LOG2_DEF  = 6;
  localparam int ADDRESS_BITS_DEF     = 32;
  localparam int MAX_WAYS_LOG2_DEF    = 3;

  // request kinds
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_WAYS_LOG2   = 1'b0;
  localparam logic REG_RANDOM_SEED = 1'b1;

  localparam logic [SEED_W-1:0] SEED_ONE = SEED_W'(1);

  typedef struct packed {
    logic [WLOG_W-1:0] ways_log2;
    logic [SEED_W-1:0] random_seed;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
  } ram_cmd_t;

  // associativity saturated at what the row layout supports
  function automatic logic [WLOG_W-1:0] eff_ways(input logic [WLOG_W-1:0] req_w,
                                                  input int cap);
    logic [WLOG_W-1:0] res;
    res = req_w;
    if (int'(req_w) > cap) begin
      res = WLOG_W'(cap);
    end
    return res;
  endfunction

endpackage

/* hdl/set_assoc_cache_tag_lookup.sv */
// set_assoc_cache_tag_lookup: tag directory top level, address split and pipeline control
// depends on sact_pkg, sact_cfg_regs, sact_tag_ram, sact_lookup
//
//   port group  direction  payload
//   in_*        slave      tuser: req_type; tdata: address
//   out_*       master     tdata: hit, way_used, filled_empty, hit_total, miss_total
//   cfg_*       apb slave  reg 0 ways_log2 at 0x0, reg 1 random_seed at 0x4
//
// one item per cycle sustained while results are taken; an item taken passes through the
// input register and the registered tag read into the result register
// rows written back in the compare stage are forwarded to the following item
// reset (synchronous, rst_n low) empties the directory via per-row flags
// a stalled result holds the compare stage; input is still taken while that stage is free

module set_assoc_cache_tag_lookup import sact_pkg::*; #(
  parameter int CACHE_BYTES_LOG2 = CACHE_BYTES_LOG2_DEF,
  parameter int LINE_BYTES_LOG2  = LINE_BYTES_LOG2_DEF,
  parameter int ADDRESS_BITS     = ADDRESS_BITS_DEF,
  parameter int MAX_WAYS_LOG2    = MAX_WAYS_LOG2_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ADDR_W-1:0]      in_tdata,   // [31:0] address
  input  logic                   in_tuser,   // [0] req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] hit, [3:1] way_used, [4] filled_empty,
                                             // [36:5] hit_total, [68:37] miss_total
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int SLOT_BITS  = CACHE_BYTES_LOG2 - LINE_BYTES_LOG2;
  localparam int LIM_A      = (MAX_WAYS_LOG2 < SLOT_BITS) ? MAX_WAYS_LOG2 : SLOT_BITS;
  localparam int LANES_LOG2 = (LIM_A < 3) ? LIM_A : 3;
  localparam int LANES      = 1 << LANES_LOG2;
  localparam int LANE_IW    = (LANES_LOG2 > 0) ? LANES_LOG2 : 1;
  localparam int ROW_BITS   = SLOT_BITS - LANES_LOG2;
  localparam int ROWS       = 1 << ROW_BITS;
  localparam int ROW_IW     = (ROW_BITS > 0) ? ROW_BITS : 1;
  localparam int ADDR_USED  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int TAG_RAW    = ADDR_USED - (CACHE_BYTES_LOG2 - LANES_LOG2);
  localparam int TAG_W      = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_USED);

  cfg_t                      cfg;
  logic [WLOG_W-1:0]         w0;
  logic [ADDR_W-1:0]         addr_m;
  logic [SLOT_BITS-1:0]      slot_idx;
  logic [SLOT_BITS-1:0]      slot_base;
  logic [ROW_IW-1:0]         row0;
  logic [LANE_IW-1:0]        lane0;
  logic [TAG_W-1:0]          tag0;
  logic                      in_acc;
  logic                      adv;
  logic                      res_valid;
  ram_cmd_t                  cmd;
  logic [LANES-1:0][TAG_W:0] wr_data;
  logic [LANES-1:0][TAG_W:0] row_data;
  logic                      res_hit;
  logic [WAY_W-1:0]          res_way;
  logic                      res_filled;
  logic [CNT_W-1:0]          res_hits;
  logic [CNT_W-1:0]          res_misses;

  logic                      s1_v_r;
  logic                      s1_req_r;
  logic [ROW_IW-1:0]         s1_row_r;
  logic [LANE_IW-1:0]        s1_lane_r;
  logic [TAG_W-1:0]          s1_tag_r;

  sact_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .reg_idx (cfg_paddr[2]),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // address split: set base slot, row of the memory and way lane within the row
  // set index is the low bits above the line offset, its slot base is set * ways
  assign w0        = eff_ways(cfg.ways_log2, LANES_LOG2);
  assign addr_m    = in_tdata & ADDR_MASK;
  assign slot_idx  = addr_m[LINE_BYTES_LOG2 +: SLOT_BITS];
  assign slot_base = slot_idx << w0;
  assign row0      = ROW_IW'(slot_base >> LANES_LOG2);
  assign lane0     = LANE_IW'(slot_base & SLOT_BITS'(LANES - 1));
  assign tag0      = TAG_W'(addr_m >> (CACHE_BYTES_LOG2 - int'(w0)));

  assign adv       = s1_v_r & (~res_valid | out_tready);
  assign in_tready = ~s1_v_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= in_tuser;
      s1_row_r  <= row0;
      s1_lane_r <= lane0;
      s1_tag_r  <= tag0;
    end
  end

  sact_tag_ram #(
    .LANES  (LANES),
    .TAG_W  (TAG_W),
    .ROWS   (ROWS),
    .ROW_IW (ROW_IW)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_row   (row0),
    .cur_row  (s1_row_r),
    .cmd      (cmd),
    .wr_row   (s1_row_r),
    .wr_data  (wr_data),
    .row_data (row_data)
  );

  sact_lookup #(
    .LANES      (LANES),
    .LANES_LOG2 (LANES_LOG2),
    .LANE_IW    (LANE_IW),
    .TAG_W      (TAG_W)
  ) u_lookup (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .cfg          (cfg),
    .req          (s1_req_r),
    .lane_base    (s1_lane_r),
    .tag          (s1_tag_r),
    .row_data     (row_data),
    .cmd          (cmd),
    .wr_data      (wr_data),
    .out_ready    (out_tready),
    .out_valid    (res_valid),
    .hit          (res_hit),
    .way_used     (res_way),
    .filled_empty (res_filled),
    .hit_total    (res_hits),
    .miss_total   (res_misses)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {3'b000, res_misses, res_hits, res_filled, res_way, res_hit};

endmodule

/* hdl/sact_cfg_regs.sv */
// sact_cfg_regs: register file behind the configuration port
// depends on sact_pkg

module sact_cfg_regs import sact_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  reg_idx,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [WLOG_W-1:0] ways_log2_r;
  logic [SEED_W-1:0] random_seed_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_log2_r   <= '0;
      random_seed_r <= SEED_ONE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WAYS_LOG2:   ways_log2_r   <= pwdata[WLOG_W-1:0];
        REG_RANDOM_SEED: random_seed_r <= pwdata[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WAYS_LOG2:   prdata = CFG_DATA_W'(ways_log2_r);
      REG_RANDOM_SEED: prdata = CFG_DATA_W'(random_seed_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.ways_log2   = ways_log2_r;
  assign cfg.random_seed = random_seed_r;

endmodule

/* hdl/sact_tag_ram.sv */
// sact_tag_ram: tag/valid memory, one row holds every way of a set
// per-row valid flags give the cleared state; last write is forwarded; uses sact_pkg

module sact_tag_ram import sact_pkg::*; #(
  parameter int LANES  = 8,
  parameter int TAG_W  = 20,
  parameter int ROWS   = 64,
  parameter int ROW_IW = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [ROW_IW-1:0]           rd_row,
  input  logic [ROW_IW-1:0]           cur_row,
  input  ram_cmd_t                    cmd,
  input  logic [ROW_IW-1:0]           wr_row,
  input  logic [LANES-1:0][TAG_W:0]   wr_data,
  output logic [LANES-1:0][TAG_W:0]   row_data
);

  logic [LANES-1:0][TAG_W:0] mem [ROWS];
  logic [LANES-1:0][TAG_W:0] rdata_r;
  logic [ROWS-1:0]           row_vld_r;
  logic                      fwd_v_r;
  logic [ROW_IW-1:0]         fwd_row_r;
  logic [LANES-1:0][TAG_W:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      fwd_v_r   <= 1'b0;
    end else if (cmd.clear) begin
      row_vld_r <= '0;
      fwd_v_r   <= 1'b0;
    end else if (cmd.wr_en) begin
      row_vld_r[wr_row] <= 1'b1;
      fwd_v_r           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      fwd_row_r  <= wr_row;
      fwd_data_r <= wr_data;
    end
  end

  // a row never written since the last clear reads as all ways invalid
  always_comb begin
    if (!row_vld_r[cur_row]) begin
      row_data = '0;
    end else if (fwd_v_r && (fwd_row_r == cur_row)) begin
      row_data = fwd_data_r;
    end else begin
      row_data = rdata_r;
    end
  end

endmodule

/* hdl/sact_lookup.sv */
// sact_lookup: tag compare, fill/victim choice, counters, lfsr and result register
// depends on sact_pkg; row data comes from sact_tag_ram

module sact_lookup import sact_pkg::*; #(
  parameter int LANES      = 8,
  parameter int LANES_LOG2 = 3,
  parameter int LANE_IW    = 3,
  parameter int TAG_W      = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  cfg_t                      cfg,
  input  logic                      req,
  input  logic [LANE_IW-1:0]        lane_base,
  input  logic [TAG_W-1:0]          tag,
  input  logic [LANES-1:0][TAG_W:0] row_data,
  output ram_cmd_t                  cmd,
  output logic [LANES-1:0][TAG_W:0] wr_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      hit,
  output logic [WAY_W-1:0]          way_used,
  output logic                      filled_empty,
  output logic [CNT_W-1:0]          hit_total,
  output logic [CNT_W-1:0]          miss_total
);

  logic [WLOG_W-1:0]  w_eff;
  logic [LANE_IW-1:0] wmask;
  logic               hit_any;
  logic [LANE_IW-1:0] hit_lane;
  logic               empty_any;
  logic [LANE_IW-1:0] empty_lane;
  logic [LANE_IW-1:0] victim_lane;
  logic [LANE_IW-1:0] fill_lane;
  logic [SEED_W-1:0]  lfsr_nxt;
  logic [SEED_W-1:0]  seed_ld;
  logic               is_lookup;

  logic               out_valid_r;
  logic               hit_r;
  logic [WAY_W-1:0]   way_r;
  logic               filled_r;
  logic [CNT_W-1:0]   hit_cnt_r;
  logic [CNT_W-1:0]   miss_cnt_r;
  logic [SEED_W-1:0]  lfsr_r;

  assign w_eff     = eff_ways(cfg.ways_log2, LANES_LOG2);
  assign wmask     = LANE_IW'((1 << w_eff) - 1);
  assign is_lookup = (req == REQ_LOOKUP);

  // lowest matching way and lowest empty way of the set, in parallel
  always_comb begin
    hit_any    = 1'b0;
    hit_lane   = '0;
    empty_any  = 1'b0;
    empty_lane = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      if ((((LANE_IW'(j) ^ lane_base) & ~wmask) == '0)) begin
        if (row_data[j][TAG_W] && (row_data[j][TAG_W-1:0] == tag)) begin
          hit_any  = 1'b1;
          hit_lane = LANE_IW'(j);
        end
        if (!row_data[j][TAG_W]) begin
          empty_any  = 1'b1;
          empty_lane = LANE_IW'(j);
        end
      end
    end
  end

  // x^16+x^14+x^13+x^11+1, shift left
  assign lfsr_nxt    = {lfsr_r[SEED_W-2:0], lfsr_r[15] ^ lfsr_r[13] ^ lfsr_r[12] ^ lfsr_r[10]};
  assign victim_lane = lane_base | (LANE_IW'(lfsr_nxt) & wmask);
  assign fill_lane   = empty_any ? empty_lane : victim_lane;
  assign seed_ld     = (cfg.random_seed != '0) ? cfg.random_seed : SEED_ONE;

  always_comb begin
    wr_data            = row_data;
    wr_data[fill_lane] = {1'b1, tag};
  end

  assign cmd.wr_en = adv & is_lookup & ~hit_any;
  assign cmd.clear = adv & ~is_lookup;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      lfsr_r      <= SEED_ONE;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        case (req)
          REQ_CLEAR: begin
            hit_cnt_r  <= '0;
            miss_cnt_r <= '0;
            lfsr_r     <= seed_ld;
          end
          default: begin
            if (hit_any) begin
              if (hit_cnt_r != '1) begin
                hit_cnt_r <= hit_cnt_r + CNT_W'(1);
              end
            end else begin
              if (miss_cnt_r != '1) begin
                miss_cnt_r <= miss_cnt_r + CNT_W'(1);
              end
              if (!empty_any) begin
                lfsr_r <= lfsr_nxt;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r    <= is_lookup & hit_any;
      filled_r <= is_lookup & ~hit_any & empty_any;
      if (!is_lookup) begin
        way_r <= '0;
      end else if (hit_any) begin
        way_r <= WAY_W'(hit_lane & wmask);
      end else begin
        way_r <= WAY_W'(fill_lane & wmask);
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign hit          = hit_r;
  assign way_used     = way_r;
  assign filled_empty = filled_r;
  assign hit_total    = hit_cnt_r;
  assign miss_total   = miss_cnt_r;

endmodule

/* hdl/sact_checker.sv */
// sact_checker: port-level checks on the tag lookup, bound to the top level
// depends on sact_pkg and set_assoc_cache_tag_lookup

module sact_checker import sact_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_psel,
  input logic                   cfg_penable,
  input logic                   cfg_pwrite,
  input logic                   cfg_pready,
  input logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input logic [CFG_DATA_W-1:0]  cfg_prdata
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a hit never reports a fill of an empty way
  a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[4])
    else $error("hit flagged together with empty fill");

  // associativity register reads back what was written
  a_ways_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2])
      ##1 !cfg_paddr[2] |-> cfg_prdata[WLOG_W-1:0] == $past(cfg_pwdata[WLOG_W-1:0]))
    else $error("ways_log2 readback mismatch");

  // no result survives a reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind set_assoc_cache_tag_lookup sact_checker u_sact_checker (.*);
